// ===== rtl/vva_pkg.sv =====
// Shared types, constants and saturation helpers for the three-component vector ALU.
package vva_pkg;

    localparam int W           = 32;
    localparam int F           = 16;
    localparam int NUM_W       = W + F;
    localparam int PROD_W      = 2 * W;
    localparam int SAT_W       = 2 * W + 4;
    localparam int RS_W        = W + 4;
    localparam int LANES       = 3;
    localparam int MULS        = 6;
    localparam int SQRT_STAGES = W;
    localparam int DIV_STAGES  = NUM_W;
    localparam int OPC_W       = 4;
    localparam int S_DATA_W    = 7 * W;
    localparam int M_DATA_W    = 4 * W;

    localparam logic signed [SAT_W-1:0] SAT_MAX = {{(SAT_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_MIN = {{(SAT_W-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [NUM_W-1:0] QPOS_LIM = {{(NUM_W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [NUM_W-1:0] QNEG_LIM = {{(NUM_W-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

    typedef logic signed [W-1:0] word_t;

    typedef enum logic [OPC_W-1:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_NEG   = 4'd2,
        OP_SCALE = 4'd3,
        OP_DIV   = 4'd4,
        OP_CROSS = 4'd5,
        OP_DOT   = 4'd6,
        OP_LEN   = 4'd7,
        OP_NORM  = 4'd8
    } op_t;

    // Per-item control and partial results that ride along the pipeline
    typedef struct packed {
        op_t                          op;
        logic                         err;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][NUM_W-1:0]  num;
        logic [W-1:0]                 dsor;
        logic [LANES-1:0][W-1:0]      res;
        logic [W-1:0]                 so;
    } side_t;

    // Clamp a wide signed value to the word range
    function automatic logic [W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
        if (v > SAT_MAX) begin
            return SAT_MAX[W-1:0];
        end else if (v < SAT_MIN) begin
            return SAT_MIN[W-1:0];
        end
        return v[W-1:0];
    endfunction

    // Apply the sign to an unsigned quotient and clamp to the word range
    function automatic logic [W-1:0] quo_word(input logic [NUM_W-1:0] q, input logic neg);
        logic [NUM_W-1:0] negq;
        negq = ~q + 1'b1;
        if (neg) begin
            if (q > QNEG_LIM) begin
                return WORD_MIN;
            end
            return negq[W-1:0];
        end
        if (q > QPOS_LIM) begin
            return WORD_MAX;
        end
        return q[W-1:0];
    endfunction

endpackage

// ===== rtl/vva_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage.
module vva_sqrt_pipe
    import vva_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [2*W-1:0]    rad_in,
    output logic [W-1:0]      root_out
);

    localparam int LAST = SQRT_STAGES - 1;

    logic [RS_W-1:0]  rem_reg  [LAST];
    logic [2*W-1:0]   rad_reg  [LAST];
    logic [W-1:0]     root_reg [SQRT_STAGES];

    genvar k;
    for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [RS_W-1:0] rem_prev;
        logic [RS_W-1:0] rem_sh;
        logic [RS_W-1:0] trial;
        logic [W-1:0]    root_prev;
        logic [2*W-1:0]  rad_prev;
        logic            fit;

        if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad_in;
        end else begin : g_next
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
        end

        // Bring down the next two radicand bits and try the new root bit
        assign rem_sh = {rem_prev[RS_W-3:0], rad_prev[2*W-1 -: 2]};
        assign trial  = {{(RS_W-W-2){1'b0}}, root_prev, 2'b01};
        assign fit    = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= {root_prev[W-2:0], fit};
            end
        end

        if (k < LAST) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= fit ? (rem_sh - trial) : rem_sh;
                    rad_reg[k] <= {rad_prev[2*W-3:0], 2'b00};
                end
            end
        end
    end

    assign root_out = root_reg[LAST];

endmodule

// ===== rtl/vva_div_lane.sv =====
// Pipelined restoring divider for one vector component, one quotient bit per stage.
module vva_div_lane
    import vva_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num_in,
    input  logic [W-1:0]      dsor_in,
    output logic [NUM_W-1:0]  quo_out
);

    localparam int LAST = DIV_STAGES - 1;

    // Numerator bits shift out the top while quotient bits shift in the bottom
    logic [NUM_W-1:0] nq_reg  [DIV_STAGES];
    logic [W-1:0]     rem_reg [LAST];
    logic [W-1:0]     d_reg   [LAST];

    genvar k;
    for (k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [W-1:0]     rem_prev;
        logic [W-1:0]     d_prev;
        logic [NUM_W-1:0] nq_prev;
        logic [W:0]       rem_sh;
        logic [W:0]       diff;
        logic             fit;

        if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign d_prev   = dsor_in;
            assign nq_prev  = num_in;
        end else begin : g_next
            assign rem_prev = rem_reg[k-1];
            assign d_prev   = d_reg[k-1];
            assign nq_prev  = nq_reg[k-1];
        end

        // Shift in one numerator bit and subtract when the divisor fits
        assign rem_sh = {rem_prev, nq_prev[NUM_W-1]};
        assign diff   = rem_sh - {1'b0, d_prev};
        assign fit    = (rem_sh >= {1'b0, d_prev});

        always_ff @(posedge aclk) begin
            if (en) begin
                nq_reg[k] <= {nq_prev[NUM_W-2:0], fit};
            end
        end

        if (k < LAST) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= fit ? diff[W-1:0] : rem_sh[W-1:0];
                    d_reg[k]   <= d_prev;
                end
            end
        end
    end

    assign quo_out = nq_reg[LAST];

endmodule

// ===== rtl/vec3_vector_alu.sv =====
// Top level of the three-component Q16.16 vector ALU: multiplier lanes, root, dividers, merge.
//
// Input channel s_*: one transaction carries vectors a and b, a scalar and an opcode
// (tuser). Output channel m_*: one transaction per input carries r_x, r_y, r_z,
// scalar_out and the error flag (tuser). Results leave in input order.
// Operations: add, sub, negate, scale, divide, cross, dot, length, normalise; all
// results saturate. Divide by zero or normalising a zero vector gives zeros with
// the error flag set; unknown opcodes give zeros.
// Every opcode takes the same path from input acceptance to m_tvalid:
// one multiply stage, one sum stage, 32 square-root stages, 48 divider stages and
// the output register. The square-root and divider depths follow from one result
// bit per stage.
// Throughput: one transaction per cycle while m_tready is high.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_tready drops; it rises again as soon as the result is taken.
// Reset (aresetn low, synchronous) empties the pipeline; no transaction is lost
// or invented after it.
module vec3_vector_alu
    import vva_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata, low to high: a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
    input  logic [S_DATA_W-1:0]   s_tdata,
    // s_tuser: opcode
    input  logic [OPC_W-1:0]      s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // m_tdata, low to high: r_x, r_y, r_z, scalar_out
    output logic [M_DATA_W-1:0]   m_tdata,
    // m_tuser: error_flag
    output logic                  m_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready
);

    localparam int PIPE_LEN = 2 + SQRT_STAGES + DIV_STAGES;

    logic                     en;
    logic [PIPE_LEN-1:0]      vld_reg;
    logic                     m_tvalid_reg;
    logic [M_DATA_W-1:0]      m_tdata_reg;
    logic [M_DATA_W-1:0]      m_tdata_next;
    logic                     m_tuser_reg;
    logic                     m_tuser_next;

    word_t                    a   [LANES];
    word_t                    b   [LANES];
    word_t                    sc;
    op_t                      op_in;
    logic [W-1:0]             abs_a [LANES];
    logic [W-1:0]             abs_s;

    word_t                    ma  [MULS];
    word_t                    mb  [MULS];
    logic signed [PROD_W-1:0] prod_reg [MULS];
    side_t                    side1_next;
    side_t                    side1_reg;

    logic signed [SAT_W-1:0]  p   [MULS];
    side_t                    side2_next;
    side_t                    side2_reg;
    logic [PROD_W-1:0]        sq_next;
    logic [PROD_W-1:0]        sq_reg;

    logic [W-1:0]             root;
    side_t                    side_sq_reg [SQRT_STAGES];
    side_t                    side_div_in;
    logic [W-1:0]             dsor_in;
    side_t                    side_dv_reg [DIV_STAGES];
    logic [NUM_W-1:0]         quo [LANES];
    side_t                    side_out;

    // Advance the pipeline whenever the output register is free or being taken
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en && aresetn;

    // Unpack the input transaction
    for (genvar i = 0; i < LANES; i++) begin : g_unpack
        assign a[i]     = s_tdata[i*W +: W];
        assign b[i]     = s_tdata[(LANES+i)*W +: W];
        assign abs_a[i] = a[i][W-1] ? (~a[i] + 1'b1) : a[i];
    end
    assign sc    = s_tdata[2*LANES*W +: W];
    assign abs_s = sc[W-1] ? (~sc + 1'b1) : sc;
    assign op_in = op_t'(s_tuser);

    // Stage 1: route operands to the multiplier lanes, finish add/sub/negate, set up divide and normalise
    always_comb begin
        side1_next    = '0;
        side1_next.op = op_in;
        for (int k = 0; k < MULS; k++) begin
            ma[k] = '0;
            mb[k] = '0;
        end
        case (op_in)
            OP_ADD: begin
                for (int i = 0; i < LANES; i++) begin
                    side1_next.res[i] = sat_word(SAT_W'(a[i]) + SAT_W'(b[i]));
                end
            end
            OP_SUB: begin
                for (int i = 0; i < LANES; i++) begin
                    side1_next.res[i] = sat_word(SAT_W'(a[i]) - SAT_W'(b[i]));
                end
            end
            OP_NEG: begin
                for (int i = 0; i < LANES; i++) begin
                    side1_next.res[i] = sat_word(-SAT_W'(a[i]));
                end
            end
            OP_SCALE: begin
                for (int i = 0; i < LANES; i++) begin
                    ma[i] = a[i];
                    mb[i] = sc;
                end
            end
            OP_DIV: begin
                side1_next.err  = (sc == '0);
                side1_next.dsor = abs_s;
                for (int i = 0; i < LANES; i++) begin
                    side1_next.neg[i] = a[i][W-1] ^ sc[W-1];
                    side1_next.num[i] = {abs_a[i], {F{1'b0}}};
                end
            end
            OP_CROSS: begin
                ma[0] = a[1]; mb[0] = b[2];
                ma[1] = a[2]; mb[1] = b[1];
                ma[2] = a[2]; mb[2] = b[0];
                ma[3] = a[0]; mb[3] = b[2];
                ma[4] = a[0]; mb[4] = b[1];
                ma[5] = a[1]; mb[5] = b[0];
            end
            OP_DOT: begin
                for (int i = 0; i < LANES; i++) begin
                    ma[i] = a[i];
                    mb[i] = b[i];
                end
            end
            OP_LEN: begin
                for (int i = 0; i < LANES; i++) begin
                    ma[i] = a[i];
                    mb[i] = a[i];
                end
            end
            OP_NORM: begin
                side1_next.err = (a[0] == '0) && (a[1] == '0) && (a[2] == '0);
                for (int i = 0; i < LANES; i++) begin
                    ma[i]             = a[i];
                    mb[i]             = a[i];
                    side1_next.neg[i] = a[i][W-1];
                    side1_next.num[i] = {abs_a[i], {F{1'b0}}};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < MULS; k++) begin
                prod_reg[k] <= PROD_W'(ma[k]) * PROD_W'(mb[k]);
            end
            side1_reg <= side1_next;
        end
    end

    // Stage 2: combine products, shift out the fraction, saturate; form the sum of squares
    for (genvar k = 0; k < MULS; k++) begin : g_ext
        assign p[k] = SAT_W'(prod_reg[k]);
    end

    always_comb begin
        side2_next = side1_reg;
        sq_next    = prod_reg[0] + prod_reg[1] + prod_reg[2];
        case (side1_reg.op)
            OP_SCALE: begin
                for (int i = 0; i < LANES; i++) begin
                    side2_next.res[i] = sat_word(p[i] >>> F);
                end
            end
            OP_CROSS: begin
                side2_next.res[0] = sat_word((p[0] - p[1]) >>> F);
                side2_next.res[1] = sat_word((p[2] - p[3]) >>> F);
                side2_next.res[2] = sat_word((p[4] - p[5]) >>> F);
            end
            OP_DOT: begin
                side2_next.so = sat_word((p[0] + p[1] + p[2]) >>> F);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg <= side2_next;
            sq_reg    <= sq_next;
        end
    end

    // Square root of the sum of squares
    vva_sqrt_pipe u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .rad_in   (sq_reg),
        .root_out (root)
    );

    // Carry the item alongside the root pipeline
    always_ff @(posedge aclk) begin
        if (en) begin
            side_sq_reg[0] <= side2_reg;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                side_sq_reg[k] <= side_sq_reg[k-1];
            end
        end
    end

    // Pick the divisor and place the length result
    always_comb begin
        side_div_in = side_sq_reg[SQRT_STAGES-1];
        if (side_div_in.op == OP_LEN) begin
            side_div_in.so = root[W-1] ? WORD_MAX : root;
        end
        dsor_in = (side_div_in.op == OP_DIV) ? side_div_in.dsor : root;
    end

    for (genvar i = 0; i < LANES; i++) begin : g_div
        vva_div_lane u_div (
            .aclk    (aclk),
            .en      (en),
            .num_in  (side_div_in.num[i]),
            .dsor_in (dsor_in),
            .quo_out (quo[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_dv_reg[0] <= side_div_in;
            for (int k = 1; k < DIV_STAGES; k++) begin
                side_dv_reg[k] <= side_dv_reg[k-1];
            end
        end
    end

    // Merge: signed quotients for divide and normalise, zeros on error
    always_comb begin
        side_out = side_dv_reg[DIV_STAGES-1];
        if (side_out.op == OP_DIV || side_out.op == OP_NORM) begin
            for (int i = 0; i < LANES; i++) begin
                side_out.res[i] = quo_word(quo[i], side_out.neg[i]);
            end
        end
        if (side_out.err) begin
            side_out.res = '0;
            side_out.so  = '0;
        end
        m_tdata_next = {side_out.so, side_out.res};
        m_tuser_next = side_out.err;
    end

    // Valid bits and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[PIPE_LEN-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[PIPE_LEN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

`ifndef SYNTHESIS
    // An error result carries only zero values
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error result with nonzero values");

    // A waiting result holds the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

    // A finished item reaches the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[PIPE_LEN-1] && en |=> m_tvalid)
        else $error("finished item lost at output");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the three-component Q16.16 vector ALU.
module tb;
    import vva_pkg::*;

    typedef logic signed [71:0] wide_t;

    typedef struct {
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
        logic [31:0] so;
        logic        err;
    } vres_t;

    // Floor of the square root of a 64-bit unsigned value
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Clamp a wide value to the signed word range
    function automatic logic [31:0] clamp_word(input wide_t v);
        if (v > wide_t'(64'sh7fffffff)) return 32'h7fffffff;
        if (v < -wide_t'(64'sh80000000)) return 32'h80000000;
        return v[31:0];
    endfunction

    // Compute the expected result of one operation
    function automatic vres_t alu_predict(input logic [3:0] op, input logic [223:0] d);
        wide_t ax, ay, az, bx, by, bz, s, rx, ry, rz, so, len;
        longint unsigned sq;
        vres_t r;
        ax = wide_t'($signed(d[31:0]));
        ay = wide_t'($signed(d[63:32]));
        az = wide_t'($signed(d[95:64]));
        bx = wide_t'($signed(d[127:96]));
        by = wide_t'($signed(d[159:128]));
        bz = wide_t'($signed(d[191:160]));
        s  = wide_t'($signed(d[223:192]));
        rx = 0; ry = 0; rz = 0; so = 0;
        r.err = 1'b0;
        case (op)
            OP_ADD: begin rx = ax + bx; ry = ay + by; rz = az + bz; end
            OP_SUB: begin rx = ax - bx; ry = ay - by; rz = az - bz; end
            OP_NEG: begin rx = -ax; ry = -ay; rz = -az; end
            OP_SCALE: begin
                rx = (ax * s) >>> 16; ry = (ay * s) >>> 16; rz = (az * s) >>> 16;
            end
            OP_DIV: begin
                if (s == 0) r.err = 1'b1;
                else begin
                    rx = (ax <<< 16) / s; ry = (ay <<< 16) / s; rz = (az <<< 16) / s;
                end
            end
            OP_CROSS: begin
                rx = (ay * bz - az * by) >>> 16;
                ry = (az * bx - ax * bz) >>> 16;
                rz = (ax * by - ay * bx) >>> 16;
            end
            OP_DOT: so = (ax * bx + ay * by + az * bz) >>> 16;
            OP_LEN: begin
                sq = 64'(ax * ax + ay * ay + az * az);
                so = wide_t'({8'd0, floor_sqrt(sq)});
            end
            OP_NORM: begin
                if (ax == 0 && ay == 0 && az == 0) r.err = 1'b1;
                else begin
                    sq = 64'(ax * ax + ay * ay + az * az);
                    len = wide_t'({8'd0, floor_sqrt(sq)});
                    rx = (ax <<< 16) / len; ry = (ay <<< 16) / len; rz = (az <<< 16) / len;
                end
            end
            default: ;
        endcase
        r.rx = clamp_word(rx);
        r.ry = clamp_word(ry);
        r.rz = clamp_word(rz);
        r.so = clamp_word(so);
        return r;
    endfunction

    // Holds the results still owed by the block, in input order
    class alu_scoreboard;
        vres_t owed[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_input(input logic [3:0] op, input logic [223:0] d);
            owed.push_back(alu_predict(op, d));
        endfunction

        task check_result(input logic [127:0] d, input logic err);
            vres_t e;
            if (owed.size() == 0) begin
                report("result with nothing pending");
                return;
            end
            e = owed.pop_front();
            if (d[31:0] !== e.rx) report($sformatf("r_x %h exp %h", d[31:0], e.rx));
            if (d[63:32] !== e.ry) report($sformatf("r_y %h exp %h", d[63:32], e.ry));
            if (d[95:64] !== e.rz) report($sformatf("r_z %h exp %h", d[95:64], e.rz));
            if (d[127:96] !== e.so) report($sformatf("scalar %h exp %h", d[127:96], e.so));
            if (err !== e.err) report($sformatf("error_flag %b exp %b", err, e.err));
        endtask
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [223:0] s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;

    alu_scoreboard sb = new();
    int burst_left = 0;

    vec3_vector_alu dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Receiver backpressure: modes of always ready, random stalls and long stalls
    int rx_mode = 0;
    int rx_left = 0;
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(10, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 19) == 0);
        endcase
    end

    // Check each result transaction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // Drive one transaction, with random gaps between bursts
    task send_item(input logic [3:0] op, input logic [223:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tdata  <= d;
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(op, d);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [223:0] vec_data(
        input logic [31:0] ax, ay, az, bx, by, bz, s);
        return {s, bz, by, bx, az, ay, ax};
    endfunction

    task wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.owed.size() != 0) @(posedge aclk);
    endtask

    localparam logic [31:0] MX = 32'h7fffffff;
    localparam logic [31:0] MN = 32'h80000000;
    localparam logic [31:0] ONE = 32'h00010000;

    initial begin
        logic [3:0]   op;
        logic [223:0] d;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes and the error cases
        send_item(OP_ADD, vec_data(MX, MN, MX, MX, MN, 0, 0));
        send_item(OP_SUB, vec_data(MN, MX, 0, MX, MN, MN, 0));
        send_item(OP_NEG, vec_data(MN, MX, 0, 0, 0, 0, 0));
        send_item(OP_SCALE, vec_data(MX, MN, MN, 0, 0, 0, MX));
        send_item(OP_SCALE, vec_data(MN, 32'hffffffff, ONE, 0, 0, 0, MN));
        send_item(OP_DIV, vec_data(ONE, MX, MN, 0, 0, 0, 0));
        send_item(OP_DIV, vec_data(MN, MX, 32'hfffe0000, 0, 0, 0, 1));
        send_item(OP_DIV, vec_data(32'h00030000, 32'hfffd0000, 7, 0, 0, 0, 32'hfffe0000));
        send_item(OP_CROSS, vec_data(MN, MX, MN, MX, MN, MX, 0));
        send_item(OP_CROSS, vec_data(ONE, 0, 0, 0, ONE, 0, 0));
        send_item(OP_DOT, vec_data(MN, MN, MN, MN, MN, MN, 0));
        send_item(OP_DOT, vec_data(3, 32'hfffffffd, 1, 5, 7, 32'hffffffff, 0));
        send_item(OP_LEN, vec_data(MN, MN, MN, 0, 0, 0, 0));
        send_item(OP_LEN, vec_data(32'h00030000, 32'h00040000, 0, 0, 0, 0, 0));
        send_item(OP_NORM, vec_data(0, 0, 0, MX, MX, MX, MX));
        send_item(OP_NORM, vec_data(MN, MN, MN, 0, 0, 0, 0));
        send_item(OP_NORM, vec_data(1, 0, 0, 0, 0, 0, 0));
        send_item(OP_NORM, vec_data(ONE, 32'hffff0000, 0, 0, 0, 0, 0));
        send_item(4'd9, vec_data(MX, MX, MX, MX, MX, MX, MX));
        send_item(4'd15, '1);

        // Random: mostly valid opcodes, with forced zero divisors and zero vectors
        for (int i = 0; i < 400; i++) begin
            if ($urandom_range(0, 19) < 18) op = 4'($urandom_range(0, 8));
            else op = 4'($urandom_range(9, 15));
            d = vec_data(pick_word(), pick_word(), pick_word(), pick_word(),
                         pick_word(), pick_word(), pick_word());
            if (op == OP_DIV && $urandom_range(0, 9) == 0) d[223:192] = '0;
            if (op == OP_NORM && $urandom_range(0, 9) == 0) d[95:0] = '0;
            send_item(op, d);
            if (i == 200) wait_drained();
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (sb.owed.size() != 0) sb.report("results still pending at end");
        if (sb.errors == 0) begin
            $display("** vec3_vector_alu: PASSED **");
        end else begin
            $display("** vec3_vector_alu: FAILED **");
        end
        $finish;
    end

    // Hard limit on run length
    initial begin
        #3000000;
        $display("** vec3_vector_alu: FAILED **");
        $finish;
    end
endmodule

// ===== vec3_vector_alu.f =====
rtl/vva_pkg.sv
rtl/vva_sqrt_pipe.sv
rtl/vva_div_lane.sv
rtl/vec3_vector_alu.sv
tb/tb.sv
